### hw/rtl/sfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants of the stereo feedback delay
// Sample, gain and accumulator widths, register codes, sequencer states,
// the shared multiply-accumulate operation and the output saturation.
// ----------------------------------------------------------------------------
package sfd_pkg;

   localparam int SampleBits  = 24;
   localparam int BufferDepth = 131072;   // power of two, line offsets wrap by truncation
   localparam int AddrBits    = $clog2(BufferDepth);
   localparam int WholeBits   = 17;
   localparam int FracBits    = 8;
   localparam int GainBits    = 16;
   localparam int GainQBits   = 17;       // clamped gain, 0 .. unity
   localparam int Unity       = 32768;
   localparam int MixShift    = 15;

   localparam int CsrIndexBits = 3;
   localparam int CsrDataBits  = 17;

   localparam int MulABits  = SampleBits + 1;
   localparam int MulBBits  = GainQBits + 1;
   localparam int ProdBits  = MulABits + MulBBits;
   localparam int AccBits   = ProdBits + 1;
   localparam int SatInBits = 32;

   localparam logic [GainQBits-1:0] UnityQ = GainQBits'(Unity);
   localparam logic signed [AccBits-1:0] MixRound = AccBits'(64'sd1 <<< (MixShift - 1));
   localparam logic signed [AccBits-1:0] InterpRound = AccBits'(64'sd1 <<< (FracBits - 1));
   localparam logic signed [SatInBits-1:0] SatMax =
      SatInBits'((64'sd1 <<< (SampleBits - 1)) - 64'sd1);
   localparam logic signed [SatInBits-1:0] SatMin = -SatMax - SatInBits'(1);

   typedef logic signed [SampleBits-1:0] sample_type;
   typedef logic [AddrBits-1:0] addr_type;

   typedef enum logic [1:0] {
      MODE_NORMAL,
      MODE_CROSS,
      MODE_PING_PONG,
      MODE_BYPASS
   } mode_type;

   typedef enum logic [CsrIndexBits-1:0] {
      REG_MODE,
      REG_STEREO,
      REG_LEFT_WHOLE,
      REG_LEFT_FRAC,
      REG_RIGHT_WHOLE,
      REG_RIGHT_FRAC,
      REG_FEEDBACK,
      REG_WET
   } csr_index_type;

   typedef struct packed {
      mode_type                 mode;
      logic                     stereo;
      logic [WholeBits-1:0]     left_whole;
      logic [FracBits-1:0]      left_frac;
      logic [WholeBits-1:0]     right_whole;
      logic [FracBits-1:0]      right_frac;
      logic [GainQBits-1:0]     gain;
      logic [GainQBits-1:0]     wet;
      logic [GainQBits-1:0]     dry;
   } cfg_type;

   typedef struct packed {
      logic                       valid;
      logic                       first;
      logic signed [MulABits-1:0] a;
      logic signed [MulBBits-1:0] b;
      logic signed [AccBits-1:0]  bias;
   } mac_op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD_NEW,
      S_RD_OLD,
      S_CAP_OLD,
      S_INTERP_L,
      S_INTERP_R,
      S_FB_L,
      S_FB_R,
      S_HOLD_FL,
      S_ROUTE,
      S_WRITE,
      S_MIX_LW,
      S_MIX_RD,
      S_MIX_RW,
      S_DRAIN,
      S_OUT
   } state_type;

   function automatic sample_type sat_sample(input logic signed [SatInBits-1:0] v);
      sample_type r;
      if (v > SatMax) begin
         r = SatMax[SampleBits-1:0];
      end else if (v < SatMin) begin
         r = SatMin[SampleBits-1:0];
      end else begin
         r = v[SampleBits-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/sfd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_if: channel interfaces of the stereo feedback delay
// Sample pair in, mixed pair out and the register write channel.
// ----------------------------------------------------------------------------
interface sfd_req_if;
   logic                 valid;
   logic                 ready;
   sfd_pkg::sample_type  left_sample;
   sfd_pkg::sample_type  right_sample;

   modport source (output valid, output left_sample, output right_sample, input ready);
   modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

interface sfd_rsp_if;
   logic                 valid;
   logic                 ready;
   sfd_pkg::sample_type  left_out;
   sfd_pkg::sample_type  right_out;

   modport source (output valid, output left_out, output right_out, input ready);
   modport sink (input valid, input left_out, input right_out, output ready);
endinterface

interface sfd_csr_if;
   logic                               valid;
   logic                               ready;
   logic [sfd_pkg::CsrIndexBits-1:0]   index;
   logic [sfd_pkg::CsrDataBits-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/sfd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_ram: generic single-write, single-read memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sfd_ram #(
   parameter int Width = 24,
   parameter int Depth = 131072
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### hw/rtl/sfd_mac.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_mac: shared multiply-accumulate unit
// Registered product, then accumulate onto a bias or the running sum.
// An operation reaches acc through the product register, then the accumulator register.
// ----------------------------------------------------------------------------
module sfd_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  sfd_pkg::mac_op_type                 op,
   output logic signed [sfd_pkg::AccBits-1:0]  acc
);

   logic signed [sfd_pkg::ProdBits-1:0] prod_ff;
   logic signed [sfd_pkg::AccBits-1:0]  bias_ff;
   logic signed [sfd_pkg::AccBits-1:0]  acc_ff;
   logic signed [sfd_pkg::AccBits-1:0]  acc_in;
   logic                                first_ff;
   logic                                valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= op.valid;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= $signed(op.a) * $signed(op.b);
      bias_ff  <= $signed(op.bias);
      first_ff <= op.first;
      if (valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   always_comb begin
      acc_in = (first_ff ? bias_ff : acc_ff) + sfd_pkg::AccBits'(prod_ff);
   end

   assign acc = acc_ff;

endmodule
`default_nettype wire

### hw/rtl/sfd_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_csr: configuration registers
// Takes register writes and presents mode, delays and clamped gains.
// ----------------------------------------------------------------------------
module sfd_csr (
   input  logic              clock,
   input  logic              reset,
   sfd_csr_if.sink           csr_if,
   output sfd_pkg::cfg_type  cfg
);

   sfd_pkg::mode_type                 mode_ff;
   logic                              stereo_ff;
   logic [sfd_pkg::WholeBits-1:0]     left_whole_ff;
   logic [sfd_pkg::FracBits-1:0]      left_frac_ff;
   logic [sfd_pkg::WholeBits-1:0]     right_whole_ff;
   logic [sfd_pkg::FracBits-1:0]      right_frac_ff;
   logic [sfd_pkg::GainBits-1:0]      gain_ff;
   logic [sfd_pkg::GainBits-1:0]      wet_ff;
   logic [sfd_pkg::GainQBits-1:0]     gain_c;
   logic [sfd_pkg::GainQBits-1:0]     wet_c;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= sfd_pkg::MODE_BYPASS;
         stereo_ff      <= 1'b1;
         left_whole_ff  <= '0;
         left_frac_ff   <= '0;
         right_whole_ff <= '0;
         right_frac_ff  <= '0;
         gain_ff        <= '0;
         wet_ff         <= '0;
      end else if (csr_if.valid) begin
         unique case (sfd_pkg::csr_index_type'(csr_if.index))
            sfd_pkg::REG_MODE: begin
               mode_ff <= sfd_pkg::mode_type'(csr_if.data[1:0]);
            end
            sfd_pkg::REG_STEREO: begin
               stereo_ff <= csr_if.data[0];
            end
            sfd_pkg::REG_LEFT_WHOLE: begin
               left_whole_ff <= csr_if.data[sfd_pkg::WholeBits-1:0];
            end
            sfd_pkg::REG_LEFT_FRAC: begin
               left_frac_ff <= csr_if.data[sfd_pkg::FracBits-1:0];
            end
            sfd_pkg::REG_RIGHT_WHOLE: begin
               right_whole_ff <= csr_if.data[sfd_pkg::WholeBits-1:0];
            end
            sfd_pkg::REG_RIGHT_FRAC: begin
               right_frac_ff <= csr_if.data[sfd_pkg::FracBits-1:0];
            end
            sfd_pkg::REG_FEEDBACK: begin
               gain_ff <= csr_if.data[sfd_pkg::GainBits-1:0];
            end
            sfd_pkg::REG_WET: begin
               wet_ff <= csr_if.data[sfd_pkg::GainBits-1:0];
            end
         endcase
      end
   end

   // gains above unity act as unity
   always_comb begin
      gain_c = (sfd_pkg::GainQBits'(gain_ff) > sfd_pkg::UnityQ) ?
               sfd_pkg::UnityQ : sfd_pkg::GainQBits'(gain_ff);
      wet_c  = (sfd_pkg::GainQBits'(wet_ff) > sfd_pkg::UnityQ) ?
               sfd_pkg::UnityQ : sfd_pkg::GainQBits'(wet_ff);
   end

   always_comb begin
      cfg.mode        = mode_ff;
      cfg.stereo      = stereo_ff;
      cfg.left_whole  = left_whole_ff;
      cfg.left_frac   = left_frac_ff;
      cfg.right_whole = right_whole_ff;
      cfg.right_frac  = right_frac_ff;
      cfg.gain        = gain_c;
      cfg.wet         = wet_c;
      cfg.dry         = sfd_pkg::UnityQ - wet_c;
   end

endmodule
`default_nettype wire

### hw/rtl/stereo_feedback_delay.sv
`timescale 1ns / 1ps
`default_nettype none
// A sample pair is taken only in the idle state and runs to the output state
// before the next is accepted (bypass goes straight to output); its eight
// multiplies go one after another through the single shared multiplier.
// Reset: synchronous; sequencer idle, write pointer zero, registers to defaults.
// The delay lines need no clearing pass: entries not yet written since reset
// read as zero, tracked by the write pointer and a wrapped flag.
// ----------------------------------------------------------------------------
// stereo_feedback_delay: stereo ping-pong feedback delay
// Two interpolated delay lines with routed feedback and wet/dry mixing,
// sequenced over one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
module stereo_feedback_delay (
   input  logic        clock,
   input  logic        reset,
   sfd_req_if.sink     req_if,
   sfd_rsp_if.source   rsp_if,
   sfd_csr_if.sink     csr_if
);

   sfd_pkg::state_type   state_ff;
   sfd_pkg::state_type   state_in;
   sfd_pkg::cfg_type     cfg;

   sfd_pkg::addr_type    wp_ff;
   sfd_pkg::addr_type    wp_in;
   logic                 full_ff;
   logic                 full_in;

   sfd_pkg::sample_type  l_ff;
   sfd_pkg::sample_type  r_ff;
   sfd_pkg::sample_type  yn_l_ff;
   sfd_pkg::sample_type  yn_r_ff;
   sfd_pkg::sample_type  yp_l_ff;
   sfd_pkg::sample_type  yp_r_ff;
   sfd_pkg::sample_type  dl_ff;
   sfd_pkg::sample_type  dr_ff;
   sfd_pkg::sample_type  lin_ff;
   sfd_pkg::sample_type  rin_ff;
   sfd_pkg::sample_type  res_l_ff;
   sfd_pkg::sample_type  res_r_ff;
   logic                 vld_l_ff;
   logic                 vld_r_ff;
   logic signed [sfd_pkg::MulABits-1:0] fl_ff;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   sfd_pkg::sample_type  rsp_left_ff;
   sfd_pkg::sample_type  rsp_right_ff;

   sfd_pkg::addr_type    new_l;
   sfd_pkg::addr_type    new_r;
   sfd_pkg::addr_type    old_l;
   sfd_pkg::addr_type    old_r;
   sfd_pkg::addr_type    rd_addr_l;
   sfd_pkg::addr_type    rd_addr_r;
   logic                 new_l_ok;
   logic                 new_r_ok;
   logic                 old_l_ok;
   logic                 old_r_ok;
   logic                 rd_en;
   logic                 wr_en;
   logic [sfd_pkg::SampleBits-1:0] ram_l_q;
   logic [sfd_pkg::SampleBits-1:0] ram_r_q;

   sfd_pkg::mac_op_type  mac_op;
   logic signed [sfd_pkg::AccBits-1:0] acc;

   logic                 in_xfer;
   logic                 out_free;
   logic                 zero_l;
   logic                 zero_r;
   sfd_pkg::sample_type  in_right;
   sfd_pkg::sample_type  lo;
   sfd_pkg::sample_type  ro;
   sfd_pkg::sample_type  acc_interp;
   sfd_pkg::sample_type  acc_mix;
   logic signed [sfd_pkg::MulABits-1:0]  acc_fb;
   logic signed [sfd_pkg::SatInBits-1:0] lin_sum;
   logic signed [sfd_pkg::SatInBits-1:0] rin_sum;
   sfd_pkg::sample_type  lin_sat;
   sfd_pkg::sample_type  rin_sat;

   sfd_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   sfd_mac u_mac (
      .clock (clock),
      .reset (reset),
      .op    (mac_op),
      .acc   (acc)
   );

   sfd_ram #(
      .Width (sfd_pkg::SampleBits),
      .Depth (sfd_pkg::BufferDepth)
   ) u_left_line (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (lin_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_l),
      .rd_data (ram_l_q)
   );

   sfd_ram #(
      .Width (sfd_pkg::SampleBits),
      .Depth (sfd_pkg::BufferDepth)
   ) u_right_line (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (rin_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_r),
      .rd_data (ram_r_q)
   );

   assign in_xfer  = req_if.valid && req_if.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign in_right = cfg.stereo ? req_if.right_sample : req_if.left_sample;

   // read taps: sample at the whole offset and the one before it
   always_comb begin
      new_l = wp_ff - cfg.left_whole[sfd_pkg::AddrBits-1:0];
      new_r = wp_ff - cfg.right_whole[sfd_pkg::AddrBits-1:0];
      old_l = new_l - sfd_pkg::AddrBits'(1);
      old_r = new_r - sfd_pkg::AddrBits'(1);
      // an entry holds data once the write pointer has passed it
      new_l_ok = full_ff || (new_l < wp_ff);
      new_r_ok = full_ff || (new_r < wp_ff);
      old_l_ok = full_ff || (old_l < wp_ff);
      old_r_ok = full_ff || (old_r < wp_ff);
   end

   always_comb begin
      zero_l     = (cfg.left_whole == '0) && (cfg.left_frac == '0);
      zero_r     = (cfg.right_whole == '0) && (cfg.right_frac == '0);
      lo         = zero_l ? lin_ff : dl_ff;
      ro         = zero_r ? rin_ff : dr_ff;
      acc_interp = acc[sfd_pkg::FracBits +: sfd_pkg::SampleBits];
      acc_fb     = acc[sfd_pkg::MixShift +: sfd_pkg::MulABits];
      acc_mix    = sfd_pkg::sat_sample(
                      sfd_pkg::SatInBits'($signed(acc[sfd_pkg::AccBits-1:sfd_pkg::MixShift])));
   end

   // feedback routing, fr straight from the accumulator
   always_comb begin
      unique case (cfg.mode)
         sfd_pkg::MODE_CROSS: begin
            lin_sum = sfd_pkg::SatInBits'(l_ff) + sfd_pkg::SatInBits'(acc_fb);
            rin_sum = sfd_pkg::SatInBits'(r_ff) + sfd_pkg::SatInBits'(fl_ff);
         end
         sfd_pkg::MODE_PING_PONG: begin
            lin_sum = sfd_pkg::SatInBits'(r_ff) + sfd_pkg::SatInBits'(acc_fb);
            rin_sum = sfd_pkg::SatInBits'(l_ff) + sfd_pkg::SatInBits'(fl_ff);
         end
         sfd_pkg::MODE_NORMAL, sfd_pkg::MODE_BYPASS: begin
            lin_sum = sfd_pkg::SatInBits'(l_ff) + sfd_pkg::SatInBits'(fl_ff);
            rin_sum = sfd_pkg::SatInBits'(r_ff) + sfd_pkg::SatInBits'(acc_fb);
         end
      endcase
      lin_sat = sfd_pkg::sat_sample(lin_sum);
      rin_sat = sfd_pkg::sat_sample(rin_sum);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sfd_pkg::S_IDLE: begin
            if (in_xfer) begin
               state_in = (cfg.mode == sfd_pkg::MODE_BYPASS) ? sfd_pkg::S_OUT
                                                            : sfd_pkg::S_RD_NEW;
            end
         end
         sfd_pkg::S_RD_NEW:   state_in = sfd_pkg::S_RD_OLD;
         sfd_pkg::S_RD_OLD:   state_in = sfd_pkg::S_CAP_OLD;
         sfd_pkg::S_CAP_OLD:  state_in = sfd_pkg::S_INTERP_L;
         sfd_pkg::S_INTERP_L: state_in = sfd_pkg::S_INTERP_R;
         sfd_pkg::S_INTERP_R: state_in = sfd_pkg::S_FB_L;
         sfd_pkg::S_FB_L:     state_in = sfd_pkg::S_FB_R;
         sfd_pkg::S_FB_R:     state_in = sfd_pkg::S_HOLD_FL;
         sfd_pkg::S_HOLD_FL:  state_in = sfd_pkg::S_ROUTE;
         sfd_pkg::S_ROUTE:    state_in = sfd_pkg::S_WRITE;
         sfd_pkg::S_WRITE:    state_in = sfd_pkg::S_MIX_LW;
         sfd_pkg::S_MIX_LW:   state_in = sfd_pkg::S_MIX_RD;
         sfd_pkg::S_MIX_RD:   state_in = sfd_pkg::S_MIX_RW;
         sfd_pkg::S_MIX_RW:   state_in = sfd_pkg::S_DRAIN;
         sfd_pkg::S_DRAIN:    state_in = sfd_pkg::S_OUT;
         sfd_pkg::S_OUT: begin
            if (out_free) begin
               state_in = sfd_pkg::S_IDLE;
            end
         end
      endcase
   end

   // sequencer outputs: handshake, memory ports, shared unit operation
   always_comb begin
      req_if.ready = 1'b0;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      rd_addr_l    = new_l;
      rd_addr_r    = new_r;
      mac_op       = '0;
      unique case (state_ff)
         sfd_pkg::S_IDLE: begin
            req_if.ready = 1'b1;
         end
         sfd_pkg::S_RD_NEW: begin
            rd_en = 1'b1;
         end
         sfd_pkg::S_RD_OLD: begin
            rd_en     = 1'b1;
            rd_addr_l = old_l;
            rd_addr_r = old_r;
         end
         sfd_pkg::S_INTERP_L: begin
            mac_op.valid = 1'b1;
            mac_op.first = 1'b1;
            mac_op.a     = sfd_pkg::MulABits'(yp_l_ff) - sfd_pkg::MulABits'(yn_l_ff);
            mac_op.b     = sfd_pkg::MulBBits'(cfg.left_frac);
            mac_op.bias  = (sfd_pkg::AccBits'(yn_l_ff) <<< sfd_pkg::FracBits)
                           + sfd_pkg::InterpRound;
         end
         sfd_pkg::S_INTERP_R: begin
            mac_op.valid = 1'b1;
            mac_op.first = 1'b1;
            mac_op.a     = sfd_pkg::MulABits'(yp_r_ff) - sfd_pkg::MulABits'(yn_r_ff);
            mac_op.b     = sfd_pkg::MulBBits'(cfg.right_frac);
            mac_op.bias  = (sfd_pkg::AccBits'(yn_r_ff) <<< sfd_pkg::FracBits)
                           + sfd_pkg::InterpRound;
         end
         sfd_pkg::S_FB_L, sfd_pkg::S_FB_R: begin
            mac_op.valid = 1'b1;
            mac_op.first = 1'b1;
            mac_op.a     = sfd_pkg::MulABits'(acc_interp);
            mac_op.b     = sfd_pkg::MulBBits'(cfg.gain);
            mac_op.bias  = sfd_pkg::MixRound;
         end
         sfd_pkg::S_WRITE: begin
            wr_en        = 1'b1;
            mac_op.valid = 1'b1;
            mac_op.first = 1'b1;
            mac_op.a     = sfd_pkg::MulABits'(l_ff);
            mac_op.b     = sfd_pkg::MulBBits'(cfg.dry);
            mac_op.bias  = sfd_pkg::MixRound;
         end
         sfd_pkg::S_MIX_LW: begin
            mac_op.valid = 1'b1;
            mac_op.a     = sfd_pkg::MulABits'(lo);
            mac_op.b     = sfd_pkg::MulBBits'(cfg.wet);
         end
         sfd_pkg::S_MIX_RD: begin
            mac_op.valid = 1'b1;
            mac_op.first = 1'b1;
            mac_op.a     = sfd_pkg::MulABits'(r_ff);
            mac_op.b     = sfd_pkg::MulBBits'(cfg.dry);
            mac_op.bias  = sfd_pkg::MixRound;
         end
         sfd_pkg::S_MIX_RW: begin
            mac_op.valid = 1'b1;
            mac_op.a     = sfd_pkg::MulABits'(ro);
            mac_op.b     = sfd_pkg::MulBBits'(cfg.wet);
         end
         sfd_pkg::S_CAP_OLD, sfd_pkg::S_HOLD_FL, sfd_pkg::S_ROUTE,
         sfd_pkg::S_DRAIN, sfd_pkg::S_OUT: begin
         end
      endcase
   end

   always_comb begin
      wp_in   = wp_ff;
      full_in = full_ff;
      if (state_ff == sfd_pkg::S_MIX_LW) begin
         wp_in   = wp_ff + sfd_pkg::AddrBits'(1);
         full_in = full_ff || (wp_ff == '1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if ((state_ff == sfd_pkg::S_OUT) && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sfd_pkg::S_IDLE;
         wp_ff        <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         sfd_pkg::S_IDLE: begin
            if (in_xfer) begin
               l_ff     <= req_if.left_sample;
               r_ff     <= in_right;
               res_l_ff <= req_if.left_sample;
               res_r_ff <= in_right;
            end
         end
         sfd_pkg::S_RD_NEW: begin
            vld_l_ff <= new_l_ok;
            vld_r_ff <= new_r_ok;
         end
         sfd_pkg::S_RD_OLD: begin
            yn_l_ff  <= vld_l_ff ? $signed(ram_l_q) : '0;
            yn_r_ff  <= vld_r_ff ? $signed(ram_r_q) : '0;
            vld_l_ff <= old_l_ok;
            vld_r_ff <= old_r_ok;
         end
         sfd_pkg::S_CAP_OLD: begin
            yp_l_ff <= vld_l_ff ? $signed(ram_l_q) : '0;
            yp_r_ff <= vld_r_ff ? $signed(ram_r_q) : '0;
         end
         sfd_pkg::S_FB_L: begin
            dl_ff <= acc_interp;
         end
         sfd_pkg::S_FB_R: begin
            dr_ff <= acc_interp;
         end
         sfd_pkg::S_HOLD_FL: begin
            fl_ff <= acc_fb;
         end
         sfd_pkg::S_ROUTE: begin
            lin_ff <= lin_sat;
            rin_ff <= cfg.stereo ? rin_sat : lin_sat;
         end
         sfd_pkg::S_MIX_RW: begin
            res_l_ff <= acc_mix;
         end
         sfd_pkg::S_OUT: begin
            // right mix settles in the accumulator here and holds while stalled
            if (out_free) begin
               rsp_left_ff  <= res_l_ff;
               rsp_right_ff <= (cfg.mode == sfd_pkg::MODE_BYPASS) ? res_r_ff :
                               (cfg.stereo ? acc_mix : res_l_ff);
            end
         end
         sfd_pkg::S_INTERP_L, sfd_pkg::S_INTERP_R, sfd_pkg::S_WRITE,
         sfd_pkg::S_MIX_LW, sfd_pkg::S_MIX_RD, sfd_pkg::S_DRAIN: begin
         end
      endcase
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.left_out  = rsp_left_ff;
   assign rsp_if.right_out = rsp_right_ff;

   a_wp_moves_once: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && ($past(state_ff) != sfd_pkg::S_MIX_LW)) |-> $stable(wp_ff))
      else $error("write pointer moved outside the mix step");

   a_bypass_skips_lines: assert property (@(posedge clock) disable iff (reset)
      (in_xfer && (cfg.mode == sfd_pkg::MODE_BYPASS)) |=> (state_ff == sfd_pkg::S_OUT))
      else $error("bypass transfer entered the delay line sequence");

   a_full_sticky: assert property (@(posedge clock) disable iff (reset)
      full_ff |=> full_ff)
      else $error("wrapped flag cleared without reset");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> ($past(state_ff) == sfd_pkg::S_OUT))
      else $error("result raised outside the output step");

endmodule
`default_nettype wire
